@@ rtl/core/touch_region_event_engine_macros.svh @@
// assertion helpers for the touch region event engine
// the using module provides clk and arst_n
`ifndef TOUCH_REGION_EVENT_ENGINE_MACROS_SVH
`define TOUCH_REGION_EVENT_ENGINE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define TREE_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define TREE_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/core/tree_pkg.sv @@
package tree_pkg;

	// table size and derived widths
	localparam int REGION_SLOTS = 16;
	localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int CNT_W = SLOT_W + 1;
	localparam int COORD_W = 12;
	localparam int ID_W = 4;

	// request codes
	localparam logic [2:0] REQ_TOUCH_DOWN = 3'd0;
	localparam logic [2:0] REQ_TOUCH_UP = 3'd1;
	localparam logic [2:0] REQ_CREATE = 3'd2;
	localparam logic [2:0] REQ_REMOVE = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// event codes
	localparam logic [2:0] KIND_DONE = 3'd0;
	localparam logic [2:0] KIND_POINT = 3'd1;
	localparam logic [2:0] KIND_PRESS = 3'd2;
	localparam logic [2:0] KIND_OVER = 3'd3;
	localparam logic [2:0] KIND_CREATED = 3'd4;
	localparam logic [2:0] KIND_FULL = 3'd5;
	localparam logic [2:0] KIND_FREE = 3'd6;

	typedef struct packed {
		logic [2:0] req_type;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
		logic [COORD_W-1:0] left_edge;
		logic [COORD_W-1:0] top_edge;
		logic [COORD_W-1:0] right_edge;
		logic [COORD_W-1:0] bottom_edge;
		logic wants_press;
		logic wants_point;
		logic wants_over;
		logic [ID_W-1:0] slot_sel;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [ID_W-1:0] slot_id;
		logic last;
	} out_item_t;

	// one word of the region memory
	typedef struct packed {
		logic [COORD_W-1:0] left_edge;
		logic [COORD_W-1:0] top_edge;
		logic [COORD_W-1:0] right_edge;
		logic [COORD_W-1:0] bottom_edge;
		logic press;
		logic point;
		logic over;
	} region_t;

	// result handed from the sequencer to the output stage
	typedef struct packed {
		logic valid;
		out_item_t item;
	} emit_t;

	// point strictly inside the rectangle
	function automatic logic inside_region(region_t r, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		return (x > r.left_edge) && (x < r.right_edge) &&
			(y > r.top_edge) && (y < r.bottom_edge);
	endfunction

endpackage

@@ rtl/core/tree_ram.sv @@
module tree_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/tree_ctrl.sv @@
module tree_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tree_pkg::in_item_t req_item,
	input logic out_free,
	output tree_pkg::emit_t emit
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_CREATE = 3'd2;
	localparam logic [2:0] ST_REMOVE = 3'd3;
	localparam logic [2:0] ST_OVER_RD = 3'd4;
	localparam logic [2:0] ST_OVER_EV = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam int N = tree_pkg::REGION_SLOTS;
	localparam int SW = tree_pkg::SLOT_W;
	localparam int CW = tree_pkg::CNT_W;

	logic [2:0] state_q;
	tree_pkg::in_item_t req_q;
	logic [N-1:0] used_q;
	logic awaiting_q;
	logic [tree_pkg::COORD_W-1:0] first_x_q;
	logic [tree_pkg::COORD_W-1:0] first_y_q;
	logic pointed_valid_q;
	logic [SW-1:0] pointed_slot_q;
	logic pressed_q;
	logic press_mode_q;
	logic [CW-1:0] cnt_q;
	logic ev_valid_s1;
	logic [SW-1:0] ev_slot_s1;

	tree_pkg::region_t rd_data;
	tree_pkg::region_t wr_data;
	logic rd_en;
	logic [SW-1:0] rd_addr;
	logic wr_en;

	logic accept;
	logic issuing;
	logic [SW-1:0] cnt_idx;
	logic ev_hit;
	logic ev_emit;
	logic adv;
	logic scan_end;
	logic cr_free;
	logic [SW-1:0] sel_idx;
	logic sel_used;
	logic over_go;

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;

	// scan and create counter
	assign issuing = (cnt_q != CW'(N));
	assign cnt_idx = cnt_q[SW-1:0];

	// evaluation of the slot whose memory word has just come back
	assign ev_hit = ev_valid_s1 && used_q[ev_slot_s1] &&
		tree_pkg::inside_region(rd_data, req_q.touch_x, req_q.touch_y) &&
		tree_pkg::inside_region(rd_data, first_x_q, first_y_q);
	assign ev_emit = ev_hit && (press_mode_q ? rd_data.press : rd_data.point);
	assign adv = !ev_emit || out_free;
	assign scan_end = !issuing && (!ev_valid_s1 || adv);

	// create and remove checks
	assign cr_free = !used_q[cnt_idx];
	assign sel_idx = SW'(req_q.slot_sel);
	assign sel_used = (int'(req_q.slot_sel) < N) && used_q[sel_idx];
	assign over_go = pointed_valid_q && !pressed_q;

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = cnt_idx;
		case (state_q)
			ST_SCAN: begin
				rd_en = adv && issuing;
			end
			ST_OVER_RD: begin
				rd_en = over_go;
				rd_addr = pointed_slot_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en = (state_q == ST_CREATE) && issuing && cr_free && out_free;

	always_comb begin
		wr_data.left_edge = req_q.left_edge;
		wr_data.top_edge = req_q.top_edge;
		wr_data.right_edge = req_q.right_edge;
		wr_data.bottom_edge = req_q.bottom_edge;
		wr_data.press = req_q.wants_press;
		wr_data.point = req_q.wants_point;
		wr_data.over = req_q.wants_over;
	end

	tree_ram #(
		.WIDTH($bits(tree_pkg::region_t)),
		.DEPTH(N)
	) u_region_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(cnt_idx),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// result items
	always_comb begin
		emit = '0;
		case (state_q)
			ST_SCAN: begin
				if (ev_emit && out_free) begin
					emit.valid = 1'b1;
					emit.item.event_kind = press_mode_q ? tree_pkg::KIND_PRESS
						: tree_pkg::KIND_POINT;
					emit.item.slot_id = tree_pkg::ID_W'(ev_slot_s1);
				end
			end
			ST_CREATE: begin
				if (out_free && !issuing) begin
					emit.valid = 1'b1;
					emit.item.event_kind = tree_pkg::KIND_FULL;
				end else if (out_free && cr_free) begin
					emit.valid = 1'b1;
					emit.item.event_kind = tree_pkg::KIND_CREATED;
					emit.item.slot_id = tree_pkg::ID_W'(cnt_idx);
				end
			end
			ST_REMOVE: begin
				if (!sel_used && out_free) begin
					emit.valid = 1'b1;
					emit.item.event_kind = tree_pkg::KIND_FREE;
					emit.item.slot_id = req_q.slot_sel;
				end
			end
			ST_OVER_EV: begin
				if (rd_data.over && out_free) begin
					emit.valid = 1'b1;
					emit.item.event_kind = tree_pkg::KIND_OVER;
					emit.item.slot_id = tree_pkg::ID_W'(pointed_slot_q);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.item.event_kind = tree_pkg::KIND_DONE;
					emit.item.last = 1'b1;
				end
			end
			default: begin
				emit = '0;
			end
		endcase
	end

	// latched request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_item;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			awaiting_q <= 1'b1;
			first_x_q <= '0;
			first_y_q <= '0;
			pointed_valid_q <= 1'b0;
			pointed_slot_q <= '0;
			pressed_q <= 1'b0;
			press_mode_q <= 1'b0;
			cnt_q <= '0;
			ev_valid_s1 <= 1'b0;
			ev_slot_s1 <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						ev_valid_s1 <= 1'b0;
						pressed_q <= 1'b0;
						case (req_item.req_type)
							tree_pkg::REQ_TOUCH_DOWN: begin
								if (awaiting_q) begin
									first_x_q <= req_item.touch_x;
									first_y_q <= req_item.touch_y;
									awaiting_q <= 1'b0;
									press_mode_q <= 1'b0;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							tree_pkg::REQ_TOUCH_UP: begin
								awaiting_q <= 1'b1;
								press_mode_q <= 1'b1;
								state_q <= awaiting_q ? ST_OVER_RD : ST_SCAN;
							end
							tree_pkg::REQ_CREATE: begin
								state_q <= ST_CREATE;
							end
							tree_pkg::REQ_REMOVE: begin
								state_q <= ST_REMOVE;
							end
							tree_pkg::REQ_CLEAR: begin
								used_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (adv) begin
						ev_valid_s1 <= issuing;
						ev_slot_s1 <= cnt_idx;
						if (issuing) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (ev_hit && !press_mode_q) begin
							pointed_slot_q <= ev_slot_s1;
							pointed_valid_q <= 1'b1;
						end
						if (ev_emit && press_mode_q) begin
							pressed_q <= 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= press_mode_q ? ST_OVER_RD : ST_DONE;
					end
				end
				ST_CREATE: begin
					if (!issuing) begin
						if (out_free) begin
							state_q <= ST_DONE;
						end
					end else if (cr_free) begin
						if (out_free) begin
							used_q[cnt_idx] <= 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_REMOVE: begin
					if (sel_used) begin
						used_q[sel_idx] <= 1'b0;
						state_q <= ST_DONE;
					end else if (out_free) begin
						state_q <= ST_DONE;
					end
				end
				ST_OVER_RD: begin
					pointed_valid_q <= 1'b0;
					state_q <= over_go ? ST_OVER_EV : ST_DONE;
				end
				ST_OVER_EV: begin
					if (!rd_data.over || out_free) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/tree_out.sv @@
module tree_out (
	input logic clk,
	input logic arst_n,
	input tree_pkg::emit_t emit,
	output logic out_free,
	output logic evt_valid,
	input logic evt_stall,
	output tree_pkg::out_item_t evt_item
);

	logic valid_q;
	tree_pkg::out_item_t item_q;

	// register is free when empty or being taken this cycle
	assign out_free = !valid_q || !evt_stall;
	assign evt_valid = valid_q;
	assign evt_item = item_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= emit.valid;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			item_q <= emit.item;
		end
	end

endmodule

@@ rtl/core/touch_region_event_engine.sv @@
// Touch region event engine. Keeps a table of REGION_SLOTS rectangles with point, press and
// over flags, and turns create, remove, clear, touch-down and touch-up requests into event
// items, each request closed by a done item with last set. One request is worked on at a
// time; req_stall is high until its done item has entered the output register. Touch-down
// and touch-up (a touch-down only with no touch open, a touch-up only with one open) walk
// the region memory one slot per cycle through its single read port, holding while the
// output register cannot take an item; touch-up then does the over check. Create walks the
// used bits one slot per cycle until the first free one and reports full when there is
// none; remove, clear and ignored requests need no walk. The used bits reset at once, so
// there is no clearing pass after reset.
`include "touch_region_event_engine_macros.svh"

module touch_region_event_engine (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input tree_pkg::in_item_t req_item,
	output logic evt_valid,
	input logic evt_stall,
	output tree_pkg::out_item_t evt_item
);

	tree_pkg::emit_t emit;
	logic out_free;

	// request sequencer with region memory
	tree_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.out_free(out_free),
		.emit(emit)
	);

	// output register
	tree_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.emit(emit),
		.out_free(out_free),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt_item(evt_item)
	);

	// checks
	`TREE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
		"request not held off")
	`TREE_ASSERT_NOW(a_last_only_done,
		evt_valid && evt_item.event_kind != tree_pkg::KIND_DONE,
		!evt_item.last, "last on non-done item")
	`TREE_ASSERT_NOW(a_full_slot_zero,
		evt_valid && evt_item.event_kind == tree_pkg::KIND_FULL,
		evt_item.slot_id == '0, "table full item with slot")

endmodule
